@@ rtl/lap3_pkg.sv @@
package lap3_pkg;

    // register sizes and reset values
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 1;
    localparam int PIX_W        = 8;

    localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 11'd480;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

    // item codes
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // kernel constants
    localparam logic [PIX_W-1:0] LAP_OFFSET = 8'd127;
    localparam logic [PIX_W-1:0] PIX_MAX    = 8'd255;

    typedef struct packed {
        logic             op;
        logic [PIX_W-1:0] pixel_in;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_out;
        logic             frame_end;
    } out_word_t;

    // per-item tag from the position counters to the datapath
    typedef struct packed {
        logic active;
        logic border;
        logic last;
    } pos_tag_t;

endpackage

@@ rtl/laplacian_3x3_offset_filter.sv @@
// 3x3 laplacian edge filter with +127 offset on a raster stream of 8-bit pixels.
// Each interior pixel becomes 8*center minus its eight neighbors plus 127,
// clamped to 0..255; pixels on the first/last row or column come out unchanged.
// A result word leaves frame_width+1 input words after its pixel went in, so
// after the last pixel of a frame the source sends frame_width+1 flush words
// (op = flush) to drain the window; frame_end marks the last pixel of the frame.
// A flush word while no frame is in progress is taken and dropped.
// Throughput is one word per clock while the output does not stall: the input
// register reads both line stores (one read and one write per store per
// cycle), the window and kernel sit between that register and the result
// register, and a word that completes a result waits in the input register,
// holding pix_stall, while a finished result is stalled at the output.
// The result is registered behind the input register. The line stores are not cleared
// after reset and need no clearing pass; their stale contents only feed border
// pixels. Writing frame_width or frame_height aborts the frame in progress;
// write them only while the block is idle.
module laplacian_3x3_offset_filter
    import lap3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // pixel input channel
    input  logic                  pix_valid,
    output logic                  pix_stall,
    input  in_word_t              pix_word,
    // result channel
    output logic                  res_valid,
    input  logic                  res_stall,
    output out_word_t             res_word,
    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]      cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic             accept;
    logic             step;
    logic             cfg_we;
    logic             flush;
    logic [PIX_W-1:0] pix_val;
    logic [CW-1:0]    col;
    pos_tag_t         tag;

    // input stage: word whose line data is being read
    logic             a_valid_reg, a_valid_next;
    pos_tag_t         a_tag_reg;
    logic [PIX_W-1:0] a_pix_reg;
    logic             a_go;

    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic             out_free;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    // flush words push zero into the window
    assign flush   = (pix_word.op == OP_FLUSH);
    assign pix_val = flush ? '0 : pix_word.pixel_in;

    // a word with no result still shifts the window, so it never waits on the output
    assign a_go      = a_valid_reg && (!a_tag_reg.active || out_free);
    assign pix_stall = a_valid_reg && !a_go;
    assign accept    = pix_valid && !pix_stall;

    lap3_seq #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .flush     (flush),
        .step      (step),
        .col       (col),
        .tag       (tag)
    );

    lap3_lines #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_lines (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (step),
        .addr   (col),
        .pix    (pix_val),
        .top    (top),
        .mid    (mid)
    );

    always_comb
    begin
        a_valid_next = a_valid_reg;
        if (step)
            a_valid_next = 1'b1;
        else if (a_go)
            a_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else
            a_valid_reg <= a_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            a_tag_reg <= tag;
            a_pix_reg <= pix_val;
        end
    end

    lap3_kernel u_kernel (
        .clk       (clk),
        .rst_n     (rst_n),
        .shift     (a_go),
        .emit      (a_go && a_tag_reg.active),
        .top       (top),
        .mid       (mid),
        .pix       (a_pix_reg),
        .tag       (a_tag_reg),
        .res_stall (res_stall),
        .res_valid (res_valid),
        .res_word  (res_word),
        .out_free  (out_free)
    );

endmodule

@@ rtl/lap3_seq.sv @@
module lap3_seq
    import lap3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]              cfg_data,
    input  logic                          accept,
    input  logic                          flush,
    output logic                          step,
    output logic [$clog2(MAX_WIDTH)-1:0]  col,
    output pos_tag_t                      tag
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int EW  = $clog2(MAX_WIDTH + 1);
    localparam int RW  = $clog2(MAX_HEIGHT + 2);
    localparam int ORW = $clog2(MAX_HEIGHT);
    localparam int EH  = $clog2(MAX_HEIGHT + 1);
    localparam int MWW = (CFG_W > EW) ? CFG_W : EW;
    localparam int MWH = (CFG_W > EH) ? CFG_W : EH;

    logic [CFG_W-1:0] frame_width_reg;
    logic [CFG_W-1:0] frame_height_reg;

    logic [CW-1:0]  in_col_reg,  in_col_next;
    logic [RW-1:0]  in_row_reg,  in_row_next;
    logic [CW-1:0]  out_col_reg, out_col_next;
    logic [ORW-1:0] out_row_reg, out_row_next;

    logic [MWW-1:0] w_ext;
    logic [MWH-1:0] h_ext;
    logic [EW-1:0]  eff_w, w_m1;
    logic [EH-1:0]  eff_h, h_m1;
    logic           ignore;
    logic           active, border, last;

    // clamp sizes to 1..MAX
    always_comb
    begin
        w_ext = MWW'(frame_width_reg);
        h_ext = MWH'(frame_height_reg);
        if (w_ext == '0)
            eff_w = EW'(1);
        else if (w_ext > MWW'(MAX_WIDTH))
            eff_w = EW'(MAX_WIDTH);
        else
            eff_w = EW'(w_ext);
        if (h_ext == '0)
            eff_h = EH'(1);
        else if (h_ext > MWH'(MAX_HEIGHT))
            eff_h = EH'(MAX_HEIGHT);
        else
            eff_h = EH'(h_ext);
        w_m1 = eff_w - EW'(1);
        h_m1 = eff_h - EH'(1);
    end

    assign ignore = flush && (in_row_reg == '0) && (in_col_reg == '0);
    assign step   = accept && !ignore;
    assign col    = in_col_reg;

    // output is due once width+1 items have gone in
    assign active = (in_row_reg > RW'(1)) || ((in_row_reg == RW'(1)) && (in_col_reg != '0));
    assign border = (out_row_reg == '0) || ((EH+1)'(out_row_reg) == (EH+1)'(h_m1))
                 || (out_col_reg == '0) || ((EW+1)'(out_col_reg) == (EW+1)'(w_m1));
    assign last   = ((EH+1)'(out_row_reg) >= (EH+1)'(h_m1))
                 && ((EW+1)'(out_col_reg) >= (EW+1)'(w_m1));

    assign tag.active = active;
    assign tag.border = border;
    assign tag.last   = last;

    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        if (cfg_we)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
        end
        else if (step)
        begin
            if ((CW+1)'(in_col_reg) + (CW+1)'(1) >= (CW+1)'(eff_w))
            begin
                in_col_next = '0;
                in_row_next = in_row_reg + RW'(1);
            end
            else
            begin
                in_col_next = in_col_reg + CW'(1);
            end
            if (active)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                end
                else if ((CW+1)'(out_col_reg) + (CW+1)'(1) >= (CW+1)'(eff_w))
                begin
                    out_col_next = '0;
                    out_row_next = out_row_reg + ORW'(1);
                end
                else
                begin
                    out_col_next = out_col_reg + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                    REG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                endcase
            end
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
        end
    end

endmodule

@@ rtl/lap3_lines.sv @@
module lap3_lines
    import lap3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          wr_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]  addr,
    input  logic [PIX_W-1:0]              pix,
    output logic [PIX_W-1:0]              top,
    output logic [PIX_W-1:0]              mid
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [PIX_W-1:0] upper_mem  [MAX_WIDTH];
    logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

    logic [PIX_W-1:0] top_rd_reg;
    logic [PIX_W-1:0] mid_rd_reg;
    logic [PIX_W-1:0] byp_data_reg;
    logic             byp_reg;
    logic [CW-1:0]    wr_addr_reg;
    logic             wr_pend_reg;

    // middle row moves up in the cycle after the read that fetched it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            middle_mem[addr] <= pix;
            mid_rd_reg       <= middle_mem[addr];
            top_rd_reg       <= upper_mem[addr];
            byp_reg          <= wr_pend_reg && (wr_addr_reg == addr);
            byp_data_reg     <= mid_rd_reg;
            wr_addr_reg      <= addr;
        end
        if (wr_pend_reg)
            upper_mem[wr_addr_reg] <= mid_rd_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            wr_pend_reg <= 1'b0;
        else
            wr_pend_reg <= wr_en;
    end

    // forward the pending upper write when one-pixel rows hit the same entry
    assign top = byp_reg ? byp_data_reg : top_rd_reg;
    assign mid = mid_rd_reg;

endmodule

@@ rtl/lap3_kernel.sv @@
module lap3_kernel
    import lap3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              shift,
    input  logic              emit,
    input  logic [PIX_W-1:0]  top,
    input  logic [PIX_W-1:0]  mid,
    input  logic [PIX_W-1:0]  pix,
    input  pos_tag_t          tag,
    input  logic              res_stall,
    output logic              res_valid,
    output out_word_t         res_word,
    output logic              out_free
);

    logic [PIX_W-1:0] win_reg [3][3];
    logic             res_valid_reg, res_valid_next;
    out_word_t        res_word_reg;

    logic [PIX_W-1:0]   center;
    logic [10:0]        nb_sum;
    logic signed [12:0] acc;
    logic [PIX_W-1:0]   lap;
    logic [PIX_W-1:0]   result;

    // window after this shift: old columns 1,2 plus the new column
    always_comb
    begin
        center = win_reg[1][2];
        nb_sum = 11'(win_reg[0][1]) + 11'(win_reg[1][1]) + 11'(win_reg[2][1])
               + 11'(win_reg[0][2]) + 11'(win_reg[2][2])
               + 11'(top) + 11'(mid) + 11'(pix);
        acc    = $signed({2'b00, center, 3'b000}) + $signed(13'(LAP_OFFSET))
               - $signed({2'b00, nb_sum});
        if (acc < 0)
            lap = '0;
        else if (acc > $signed(13'(PIX_MAX)))
            lap = PIX_MAX;
        else
            lap = acc[PIX_W-1:0];
        result = tag.border ? center : lap;
    end

    assign out_free = !res_valid_reg || !res_stall;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (emit)
            res_valid_next = 1'b1;
        else if (!res_stall)
            res_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    win_reg[r][k] <= '0;
                end
            end
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (shift)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r][0] <= win_reg[r][1];
                    win_reg[r][1] <= win_reg[r][2];
                end
                win_reg[0][2] <= top;
                win_reg[1][2] <= mid;
                win_reg[2][2] <= pix;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            res_word_reg.pixel_out <= result;
            res_word_reg.frame_end <= tag.last;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_word  = res_word_reg;

endmodule

@@ tb/sv/lap3_filter_checker.sv @@
`timescale 1ns / 1ps
module lap3_filter_checker
    import lap3_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 pix_valid,
    input  logic                 pix_stall,
    input  in_word_t             pix_word,
    input  logic                 res_valid,
    input  logic                 res_stall,
    input  out_word_t            res_word,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data,
    input  logic                 end_check,
    output int                   errors,
    output int                   pending
);

    localparam int CENTER_GAIN = 8;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [PIX_W-1:0] upper_row [MAX_WIDTH];
    logic [PIX_W-1:0] middle_row [MAX_WIDTH];
    logic [PIX_W-1:0] win [3][3];
    int unsigned      in_col;
    int unsigned      in_line;
    int unsigned      out_col;
    int unsigned      out_line;
    out_word_t        expected_q [$];
    int               mismatches;

    // words still owed count against the run once the top closes it
    assign errors = mismatches + (end_check ? pending : 0);

    function automatic int unsigned clamp_size(logic [CFG_W-1:0] v, int unsigned limit);
        if (v == '0)
            return 1;
        if (v > limit)
            return limit;
        return 32'(v);
    endfunction

    task automatic restart_frame();
        in_col   = 0;
        in_line  = 0;
        out_col  = 0;
        out_line = 0;
    endtask

    task automatic filter_word(input in_word_t w);
        int unsigned      cols;
        int unsigned      rows;
        int unsigned      c;
        logic [PIX_W-1:0] v;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] mid;
        bit               due;
        bit               last;
        int               acc;
        int               r;
        int               k;
        out_word_t        res;
        cols = clamp_size(width_reg, MAX_WIDTH);
        rows = clamp_size(height_reg, MAX_HEIGHT);
        // flush with no frame open is dropped
        if (w.op == OP_FLUSH && in_line == 0 && in_col == 0)
            return;
        v = (w.op == OP_FLUSH) ? '0 : w.pixel_in;
        c = in_col;
        top = upper_row[c];
        mid = middle_row[c];
        upper_row[c]  = mid;
        middle_row[c] = v;
        for (r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = mid;
        win[2][2] = v;
        due = (in_line > 1) || (in_line == 1 && in_col >= 1);
        in_col++;
        if (in_col >= cols)
        begin
            in_col = 0;
            in_line++;
        end
        if (!due)
            return;
        if (out_line == 0 || out_line == rows - 1 || out_col == 0 || out_col == cols - 1)
            res.pixel_out = win[1][1];
        else
        begin
            acc = CENTER_GAIN * int'(win[1][1]);
            for (r = 0; r < 3; r++)
                for (k = 0; k < 3; k++)
                    if (r != 1 || k != 1)
                        acc -= int'(win[r][k]);
            acc += int'(LAP_OFFSET);
            if (acc > int'(PIX_MAX))
                acc = int'(PIX_MAX);
            if (acc < 0)
                acc = 0;
            res.pixel_out = acc[PIX_W-1:0];
        end
        last = (out_line >= rows - 1) && (out_col >= cols - 1);
        res.frame_end = last;
        expected_q.push_back(res);
        if (last)
            restart_frame();
        else
        begin
            out_col++;
            if (out_col >= cols)
            begin
                out_col = 0;
                out_line++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            width_reg  = RST_FRAME_WIDTH;
            height_reg = RST_FRAME_HEIGHT;
            for (int i = 0; i < MAX_WIDTH; i++)
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                    win[r][k] = '0;
            restart_frame();
            expected_q.delete();
            mismatches = 0;
            pending    = 0;
        end
        else
        begin
            // results first: a word taken at this edge cannot be answered yet
            if (res_valid && !res_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result word with nothing predicted: pixel_out %0d frame_end %0d",
                           res_word.pixel_out, res_word.frame_end);
                    mismatches++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (res_word.pixel_out !== want.pixel_out)
                    begin
                        $error("pixel_out: expected %0d, got %0d",
                               want.pixel_out, res_word.pixel_out);
                        mismatches++;
                    end
                    if (res_word.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0d, got %0d",
                               want.frame_end, res_word.frame_end);
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_FRAME_WIDTH)
                    width_reg = cfg_data;
                else if (cfg_index == REG_FRAME_HEIGHT)
                    height_reg = cfg_data;
                restart_frame();
            end
            if (pix_valid && !pix_stall)
                filter_word(pix_word);
            pending = expected_q.size();
        end
    end

    always @(posedge end_check)
    begin
        if (pending != 0)
            $error("%0d predicted result words never arrived", pending);
    end

endmodule

@@ tb/sv/laplacian_3x3_offset_filter_tb.sv @@
`timescale 1ns / 1ps
module laplacian_3x3_offset_filter_tb;
    import lap3_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    // pipeline settle time plus margin
    localparam int SETTLE_CYCLES = 8;
    localparam int RANDOM_ITEMS  = 400;
    localparam int MAX_SIDE      = 1024;

    // traffic shapes on the two word channels
    typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SNK_STALL, FLOW_BOTH} flow_e;
    // image content styles
    typedef enum int {TEX_NOISE, TEX_BINARY, TEX_SMOOTH} tex_e;

    logic                 clk;
    logic                 rst_n;
    logic                 pix_valid;
    logic                 pix_stall;
    in_word_t             pix_word;
    logic                 res_valid;
    logic                 res_stall;
    out_word_t            res_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;
    logic                 end_check;
    int                   errors;
    int                   pending;

    int unsigned          src_idle_pct;
    int unsigned          snk_stall_pct;
    // register values the block currently holds
    logic [CFG_W-1:0]     width_now;
    logic [CFG_W-1:0]     height_now;
    int                   cycles = 0;
    int                   random_sent;

    laplacian_3x3_offset_filter i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lap3_filter_checker i_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix_word  (pix_word),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_word  (res_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .end_check (end_check),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // receiver back-pressure, redrawn every falling edge
    always @(negedge clk)
        res_stall = ($urandom_range(99) < snk_stall_pct);

    // hang guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic set_flow(input flow_e f);
        case (f)
            FLOW_FREE:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 0;
            end
            FLOW_SRC_IDLE:
            begin
                src_idle_pct  = 56;
                snk_stall_pct = 0;
            end
            FLOW_SNK_STALL:
            begin
                src_idle_pct  = 0;
                snk_stall_pct = 56;
            end
            default:
            begin
                src_idle_pct  = 16;
                snk_stall_pct = 16;
            end
        endcase
    endtask

    // all tasks below start and end just after a falling edge
    task automatic send_word(input logic op, input logic [PIX_W-1:0] px);
        in_word_t w;
        w.op       = op;
        w.pixel_in = px;
        // optional idle cycles before the word shows up
        while ($urandom_range(99) < src_idle_pct)
            @(negedge clk);
        pix_valid = 1'b1;
        pix_word  = w;
        // hold the word until a clean edge takes it
        do
            @(posedge clk);
        while (pix_stall);
        @(negedge clk);
        // the next send may raise valid again in this same step
        pix_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // registers only change with the pipe empty and settled
    task automatic set_size(input logic [CFG_W-1:0] w_reg, input logic [CFG_W-1:0] h_reg);
        if (w_reg != width_now || h_reg != height_now)
        begin
            wait_drained();
            repeat (SETTLE_CYCLES) @(negedge clk);
            if (w_reg != width_now)
            begin
                write_reg(REG_FRAME_WIDTH, w_reg);
                width_now = w_reg;
            end
            if (h_reg != height_now)
            begin
                write_reg(REG_FRAME_HEIGHT, h_reg);
                height_now = h_reg;
            end
        end
    endtask

    function automatic logic [PIX_W-1:0] pixel_for(input tex_e style, input int unsigned base);
        int t;
        case (style)
            TEX_NOISE:
                return 8'($urandom_range(255));
            TEX_BINARY:
                return $urandom_range(1) ? PIX_MAX : '0;
            default:
            begin
                t = int'(base) + int'($urandom_range(16)) - 8;
                if (t < 0)
                    t = 0;
                if (t > 255)
                    t = 255;
                return t[PIX_W-1:0];
            end
        endcase
    endfunction

    // one full frame: pixels, then width+1 drain words
    task automatic run_frame(input logic [CFG_W-1:0] w_reg, input logic [CFG_W-1:0] h_reg,
                             input bit hold_mid);
        int unsigned cols;
        int unsigned rows;
        int unsigned total;
        int unsigned base;
        tex_e        style;
        set_size(w_reg, h_reg);
        cols  = (w_reg == '0) ? 1 : ((32'(w_reg) > MAX_SIDE) ? MAX_SIDE : 32'(w_reg));
        rows  = (h_reg == '0) ? 1 : ((32'(h_reg) > MAX_SIDE) ? MAX_SIDE : 32'(h_reg));
        total = cols * rows;
        style = tex_e'($urandom_range(2));
        base  = $urandom_range(255);
        // stray flush between frames, dropped by the block
        if ($urandom_range(5) == 0)
            send_word(OP_FLUSH, 8'($urandom_range(255)));
        for (int unsigned i = 0; i < total; i++)
        begin
            // hold off mid-frame until every owed word is out
            if (hold_mid && i == total / 2)
            begin
                wait_drained();
                repeat ($urandom_range(1, 6)) @(negedge clk);
            end
            // occasional flush inside the frame stands in for a zero pixel
            if (i != 0 && $urandom_range(19) == 0)
                send_word(OP_FLUSH, 8'($urandom_range(255)));
            else
                send_word(OP_PIXEL, pixel_for(style, base));
        end
        // drain, sometimes with surplus pixels instead of flushes
        for (int unsigned j = 0; j <= cols; j++)
        begin
            if ($urandom_range(3) == 0)
                send_word(OP_PIXEL, pixel_for(style, base));
            else
                send_word(OP_FLUSH, 8'($urandom_range(255)));
        end
        random_sent += int'(total + cols + 1);
    endtask

    // 3x3 tile with one value in the middle and another around it
    task automatic run_tile(input logic [PIX_W-1:0] center, input logic [PIX_W-1:0] ring,
                            input bit pixel_drain);
        set_size(11'd3, 11'd3);
        for (int i = 0; i < 9; i++)
        begin
            send_word(OP_PIXEL, (i == 4) ? center : ring);
            if (i == 4)
                wait_drained();
        end
        for (int j = 0; j < 4; j++)
        begin
            if (pixel_drain)
                send_word(OP_PIXEL, j[0] ? PIX_MAX : 8'd0);
            else
                send_word(OP_FLUSH, j[0] ? PIX_MAX : 8'd0);
        end
    endtask

    initial
    begin
        flow_e            flow;
        logic [CFG_W-1:0] w_pick;
        logic [CFG_W-1:0] h_pick;
        int               frame_no;
        int unsigned      sel;

        rst_n         = 1'b0;
        pix_valid     = 1'b0;
        pix_word      = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        end_check     = 1'b0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        width_now     = RST_FRAME_WIDTH;
        height_now    = RST_FRAME_HEIGHT;
        random_sent   = 0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: idle flush, saturating kernel both ways, surplus pixels in the drain
        set_flow(FLOW_FREE);
        set_size(11'd3, 11'd3);
        send_word(OP_FLUSH, PIX_MAX);
        run_tile(PIX_MAX, 8'd0, 1'b0);
        run_tile(8'd0, PIX_MAX, 1'b1);

        // single-pixel frame
        set_flow(FLOW_BOTH);
        run_frame(11'd1, 11'd1, 1'b0);

        // random frames, mostly small, cycling through the traffic shapes
        random_sent = 0;
        frame_no    = 0;
        w_pick      = width_now;
        h_pick      = height_now;
        while (random_sent < RANDOM_ITEMS)
        begin
            flow = flow_e'(frame_no % 4);
            set_flow(flow);
            // keep the size now and then so frames run back to back
            if ($urandom_range(2) != 0)
            begin
                sel = $urandom_range(9);
                case (sel)
                    0:
                    begin
                        w_pick = 11'd1;
                        h_pick = 11'($urandom_range(1, 6));
                    end
                    1:
                    begin
                        w_pick = 11'($urandom_range(1, 8));
                        h_pick = 11'd1;
                    end
                    2:
                    begin
                        w_pick = $urandom_range(1) ? 11'd0 : 11'($urandom_range(2, 6));
                        h_pick = $urandom_range(1) ? 11'd0 : 11'($urandom_range(2, 6));
                    end
                    default:
                    begin
                        w_pick = 11'($urandom_range(2, 10));
                        h_pick = 11'($urandom_range(2, 8));
                    end
                endcase
            end
            run_frame(w_pick, h_pick, $urandom_range(4) == 0);
            frame_no++;
        end

        // let the tail drain, then close out
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        end_check = 1'b1;
        @(negedge clk);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
